@@ hw/rtl/ising_spin_flip_update_defines.svh @@
// Assertion macros for the Ising spin update block.
`ifndef ISING_SPIN_FLIP_UPDATE_DEFINES_SVH
`define ISING_SPIN_FLIP_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ISF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isf: assertion failed");
`define ISF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isf: assertion failed");
`else
`define ISF_ASSERT_IMP(lbl, ante, cons)
`define ISF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/isf_pkg.sv @@
// Types and constants of the Ising spin update block.
package isf_pkg;

  localparam int SIDE_DEF      = 32;
  localparam int DRAW_BITS_DEF = 16;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 5;
  localparam int LIMIT_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int ENERGY_W  = 13;
  localparam int MAGNET_W  = 12;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE,
    OP_METRO,
    OP_HEAT,
    OP_READ
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METRO4,
    REG_METRO8,
    REG_HEAT2,
    REG_HEAT4
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] METRO4_RST = 17'd1200;
  localparam logic [LIMIT_W-1:0] METRO8_RST = 17'd22;
  localparam logic [LIMIT_W-1:0] HEAT2_RST  = 17'd64357;
  localparam logic [LIMIT_W-1:0] HEAT4_RST  = 17'd65514;

  typedef struct packed {
    logic                site_spin;
    logic                flipped;
    logic [ENERGY_W-1:0] energy;
    logic [MAGNET_W-1:0] magnet;
  } result_t;

endpackage

@@ hw/rtl/isf_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module isf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/ising_spin_flip_update.sv @@
// Ising lattice spin update: top level with lattice memory, update pipeline and result queue.
//
// Lattice held one row per memory word in a two-read-port RAM. An item passes stages A, B
// and C before its result is registered in the result queue. No item is taken while one is
// in stage B or while the queue lacks room. The upper neighbour row is read in the accept
// cycle, the site row and lower neighbour row in the next, and the update and write-back
// happen in stage C, overlapping the next item's first read (forwarded). After reset a
// clearing pass writes all rows to +1, during which no items are taken. A two-entry result
// queue lets items be accepted while a finished result waits.
`include "ising_spin_flip_update_defines.svh"

module ising_spin_flip_update import isf_pkg::*; #(
  parameter int SIDE      = SIDE_DEF,
  parameter int DRAW_BITS = DRAW_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [LIMIT_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_opcode,
  input  logic [COORD_W-1:0]         in_site_row,
  input  logic [COORD_W-1:0]         in_site_col,
  input  logic                       in_spin_value,
  input  logic [DRAW_BITS-1:0]       in_random_draw,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_site_spin,
  output logic                       out_flipped,
  output logic signed [ENERGY_W-1:0] out_energy,
  output logic signed [MAGNET_W-1:0] out_magnetization
);

  localparam int RW     = $clog2(SIDE);
  localparam int COORDS = 1 << COORD_W;
  localparam int TW     = (DRAW_BITS + 1 > LIMIT_W) ? DRAW_BITS + 1 : LIMIT_W;

  localparam logic [RW-1:0]       LAST       = RW'(SIDE - 1);
  localparam logic [TW-1:0]       FULL       = TW'(1) << DRAW_BITS;
  localparam logic [TW-1:0]       HALF       = TW'(1) << (DRAW_BITS - 1);
  localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-2 * SIDE * SIDE);
  localparam logic [MAGNET_W-1:0] MAGNET_RST = MAGNET_W'(SIDE * SIDE);

  // configuration
  logic [LIMIT_W-1:0] lim_metro4_r, lim_metro8_r, lim_heat2_r, lim_heat4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_metro4_r <= METRO4_RST;
      lim_metro8_r <= METRO8_RST;
      lim_heat2_r  <= HEAT2_RST;
      lim_heat4_r  <= HEAT4_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_METRO4: lim_metro4_r <= cfg_data;
        REG_METRO8: lim_metro8_r <= cfg_data;
        REG_HEAT2:  lim_heat2_r  <= cfg_data;
        REG_HEAT4:  lim_heat4_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [TW-1:0] thr_m4, thr_m8, thr_h2, thr_h4;

  always_comb begin
    thr_m4 = (TW'(lim_metro4_r) > FULL) ? FULL : TW'(lim_metro4_r);
    thr_m8 = (TW'(lim_metro8_r) > FULL) ? FULL : TW'(lim_metro8_r);
    thr_h2 = (TW'(lim_heat2_r)  > FULL) ? FULL : TW'(lim_heat2_r);
    thr_h4 = (TW'(lim_heat4_r)  > FULL) ? FULL : TW'(lim_heat4_r);
  end

  // coordinate reduction table
  logic [RW-1:0] coord_mod [COORDS];

  for (genvar gi = 0; gi < COORDS; gi++) begin : g_mod
    assign coord_mod[gi] = RW'(gi % SIDE);
  end

  // lattice memory
  logic            mem_we;
  logic [RW-1:0]   mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [SIDE-1:0] mem_wdata, rd_a, rd_b;

  isf_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_lattice (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .rdata_a (rd_a),
    .raddr_b (mem_raddr_b),
    .rdata_b (rd_b)
  );

  // clearing pass
  logic          clr_active_r;
  logic [RW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + RW'(1);
      if (clr_addr_r == LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // result queue state
  result_t     fifo_q [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  fifo_cnt_r, fifo_cnt_nxt;
  logic        fifo_push, fifo_pop;

  // stage A: accept, read upper row
  logic          s1_vld_r, s2_vld_r;
  logic          in_acc;
  logic [RW-1:0] row_a, col_a, rm_a, rp_a;

  assign in_ready = !clr_active_r && !s1_vld_r &&
                    ((fifo_cnt_r == 2'd0) || (fifo_cnt_r == 2'd1 && !s2_vld_r));
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    row_a = coord_mod[in_site_row];
    col_a = coord_mod[in_site_col];
    rm_a  = (row_a == '0) ? LAST : row_a - RW'(1);
    rp_a  = (row_a == LAST) ? '0 : row_a + RW'(1);
  end

  opcode_t          s1_op_r, s2_op_r;
  logic [RW-1:0]    s1_row_r, s1_rp_r, s1_col_r, s2_row_r, s2_col_r;
  logic             s1_want_r, s2_want_r;
  logic [DRAW_BITS-1:0] s1_draw_r, s2_draw_r;
  logic             s1_fwd_r;
  logic [SIDE-1:0]  s1_fwd_row_r, row_up_r;

  assign mem_raddr_a = s1_vld_r ? s1_row_r : rm_a;
  assign mem_raddr_b = s1_rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r      <= opcode_t'(in_opcode);
      s1_row_r     <= row_a;
      s1_rp_r      <= rp_a;
      s1_col_r     <= col_a;
      s1_want_r    <= in_spin_value;
      s1_draw_r    <= in_random_draw;
      s1_fwd_r     <= mem_we && (mem_waddr == rm_a);
      s1_fwd_row_r <= mem_wdata;
    end
    // stage B: capture upper row, read site and lower rows
    if (s1_vld_r) begin
      row_up_r  <= s1_fwd_r ? s1_fwd_row_r : rd_a;
      s2_op_r   <= s1_op_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_want_r <= s1_want_r;
      s2_draw_r <= s1_draw_r;
    end
  end

  // stage C: update and write back
  logic [RW-1:0]       cp, cm;
  logic                s_old, s_new, flip, metro_acc;
  logic [2:0]          up, aligned;
  logic [TW-1:0]       heat_thr, draw_x;
  logic [SIDE-1:0]     new_row;
  logic [ENERGY_W-1:0] e_delta, energy_r, energy_nxt;
  logic [MAGNET_W-1:0] magnet_r, magnet_nxt;

  always_comb begin
    cp      = (s2_col_r == LAST) ? '0 : s2_col_r + RW'(1);
    cm      = (s2_col_r == '0) ? LAST : s2_col_r - RW'(1);
    s_old   = rd_a[s2_col_r];
    up      = {2'b00, row_up_r[s2_col_r]} + {2'b00, rd_b[s2_col_r]} +
              {2'b00, rd_a[cp]} + {2'b00, rd_a[cm]};
    aligned = s_old ? up : 3'd4 - up;
    draw_x  = TW'(s2_draw_r);

    case (aligned)
      3'd3:    metro_acc = draw_x < thr_m4;
      3'd4:    metro_acc = draw_x < thr_m8;
      default: metro_acc = 1'b1;
    endcase

    case (up)
      3'd0:    heat_thr = FULL - thr_h4;
      3'd1:    heat_thr = FULL - thr_h2;
      3'd2:    heat_thr = HALF;
      3'd3:    heat_thr = thr_h2;
      default: heat_thr = thr_h4;
    endcase

    case (s2_op_r)
      OP_WRITE: s_new = s2_want_r;
      OP_METRO: s_new = metro_acc ? !s_old : s_old;
      OP_HEAT:  s_new = draw_x < heat_thr;
      default:  s_new = s_old;
    endcase

    flip = s_new != s_old;

    case (aligned)
      3'd0:    e_delta = ENERGY_W'(-8);
      3'd1:    e_delta = ENERGY_W'(-4);
      3'd3:    e_delta = ENERGY_W'(4);
      3'd4:    e_delta = ENERGY_W'(8);
      default: e_delta = '0;
    endcase

    energy_nxt = energy_r;
    magnet_nxt = magnet_r;
    if (s2_vld_r && flip) begin
      energy_nxt = energy_r + e_delta;
      magnet_nxt = s_old ? magnet_r - MAGNET_W'(2) : magnet_r + MAGNET_W'(2);
    end

    new_row           = rd_a;
    new_row[s2_col_r] = s_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= ENERGY_RST;
      magnet_r <= MAGNET_RST;
    end else begin
      energy_r <= energy_nxt;
      magnet_r <= magnet_nxt;
    end
  end

  assign mem_we    = clr_active_r || (s2_vld_r && flip);
  assign mem_waddr = clr_active_r ? clr_addr_r : s2_row_r;
  assign mem_wdata = clr_active_r ? '1 : new_row;

  // result queue
  assign fifo_push = s2_vld_r;
  assign fifo_pop  = out_valid && out_ready;

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (fifo_push && !fifo_pop) begin
      fifo_cnt_nxt = fifo_cnt_r + 2'd1;
    end else if (!fifo_push && fifo_pop) begin
      fifo_cnt_nxt = fifo_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= 2'd0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (fifo_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (fifo_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_r] <= '{site_spin: s_new, flipped: flip,
                            energy: energy_nxt, magnet: magnet_nxt};
    end
  end

  assign out_valid         = fifo_cnt_r != 2'd0;
  assign out_site_spin     = fifo_q[rd_ptr_r].site_spin;
  assign out_flipped       = fifo_q[rd_ptr_r].flipped;
  assign out_energy        = fifo_q[rd_ptr_r].energy;
  assign out_magnetization = fifo_q[rd_ptr_r].magnet;

  `ISF_ASSERT_IMP(a_no_acc_clr, clr_active_r, !in_ready)
  `ISF_ASSERT_IMP(a_no_wr_site_read, s1_vld_r, !mem_we)
  `ISF_ASSERT_IMP(a_fifo_room, fifo_push && !fifo_pop, fifo_cnt_r != 2'd2)
  `ISF_ASSERT_NXT(a_s1_to_s2, s1_vld_r, s2_vld_r)
  `ISF_ASSERT_IMP(a_read_no_flip, s2_vld_r && s2_op_r == OP_READ, !flip)

endmodule
